### src/u8sd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

	// replacement character for a bad or cut-off lead
	localparam logic [20:0] QMARK = 21'd63;

	// lengths that a lead byte announces
	localparam logic [2:0] LEN_BAD = 3'd0;
	localparam logic [2:0] LEN_ONE = 3'd1;
	localparam logic [2:0] LEN_TWO = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// results that one byte can cause at most
	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0]  used_bytes;
		logic        stream_end;
	} res_t;

	// results of one byte, head first
	typedef struct packed {
		logic [1:0]          count;
		res_t [MAX_RES-1:0]  res;
	} dec_t;

endpackage

`default_nettype wire

### src/u8sd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface u8sd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

`default_nettype wire

### src/u8sd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface u8sd_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [2:0]  used_bytes;
	logic        stream_end;

	modport source (output valid, output code_point, output used_bytes,
		output stream_end, input ready);
	modport sink (input valid, input code_point, input used_bytes,
		input stream_end, output ready);
endinterface

`default_nettype wire

### src/u8sd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module u8sd_core
	import u8sd_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire [7:0]  byte_s1,
	input  wire        last_s1,
	input  wire        take,
	output dec_t       dec
);

	logic [7:0] held_q [3];
	logic [1:0] cnt_q;
	logic [2:0] need_q;

	function automatic logic [2:0] lead_len(input logic [7:0] c0);
		logic [2:0] len;
		if (c0[7] == 1'b0) len = LEN_ONE;
		else if (c0[7:5] == 3'b110) len = LEN_TWO;
		else if (c0[7:4] == 4'b1110) len = LEN_THREE;
		else if (c0[7:3] == 5'b11110) len = LEN_FOUR;
		else len = LEN_BAD;
		return len;
	endfunction

	// decode one code point starting at pos within the first n bytes
	function automatic res_t decode_at(input logic [3:0][7:0] bv, input logic [3:0] pos,
			input logic [2:0] n);
		logic [7:0] c0, b1, b2, b3;
		logic [2:0] len;
		res_t r;
		c0 = bv[pos[1:0]];
		b1 = bv[pos[1:0] + 2'd1];
		b2 = bv[pos[1:0] + 2'd2];
		b3 = bv[pos[1:0] + 2'd3];
		len = lead_len(c0);
		r.stream_end = 1'b0;
		r.code_point = QMARK;
		r.used_bytes = 3'd1;
		if (len == LEN_ONE) begin
			r.code_point = {13'd0, c0};
		end else if (len != LEN_BAD && (pos + {1'b0, len}) <= {1'b0, n}) begin
			r.used_bytes = len;
			case (len)
				LEN_TWO:   r.code_point = {10'd0, c0[4:0], b1[5:0]};
				LEN_THREE: r.code_point = {5'd0, c0[3:0], b1[5:0], b2[5:0]};
				default:   r.code_point = {c0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			endcase
		end
		return r;
	endfunction

	logic [3:0][7:0] bv;
	logic [2:0]      n;
	logic [2:0]      len_new;
	logic [3:0]      pos1, pos2;
	logic            v1, v2;
	logic            emit;
	res_t            r0, r1, r2;

	// held bytes followed by the new one
	always_comb begin
		bv[0] = (cnt_q > 2'd0) ? held_q[0] : byte_s1;
		bv[1] = (cnt_q > 2'd1) ? held_q[1] : byte_s1;
		bv[2] = (cnt_q > 2'd2) ? held_q[2] : byte_s1;
		bv[3] = byte_s1;
	end

	assign n = {1'b0, cnt_q} + 3'd1;
	assign len_new = lead_len(byte_s1);

	// up to three code points chained through the buffer
	always_comb begin
		r0 = decode_at(bv, 4'd0, n);
		pos1 = {1'b0, r0.used_bytes};
		v1 = pos1 < {1'b0, n};
		r1 = decode_at(bv, pos1, n);
		pos2 = pos1 + {1'b0, r1.used_bytes};
		v2 = pos2 < {1'b0, n};
		r2 = decode_at(bv, pos2, n);
		r0.stream_end = last_s1 && !v1;
		r1.stream_end = last_s1 && !v2;
		r2.stream_end = last_s1;
	end

	// a sequence completes, or a single byte stands alone
	assign emit = (cnt_q == 2'd0) ? (len_new <= LEN_ONE) : (n >= need_q);

	always_comb begin
		dec.res[0] = r0;
		dec.res[1] = r1;
		dec.res[2] = r2;
		if (last_s1) dec.count = 2'd1 + {1'b0, v1} + {1'b0, v1 && v2};
		else if (emit) dec.count = 2'd1;
		else dec.count = 2'd0;
	end

	// held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			need_q <= 3'd0;
		end else if (take) begin
			if (last_s1 || emit) begin
				cnt_q <= 2'd0;
				need_q <= 3'd0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd0) need_q <= len_new;
			end
		end
	end

	// held bytes, written in order
	always_ff @(posedge clk) begin
		if (take && !last_s1 && !emit) begin
			if (cnt_q == 2'd0) held_q[0] <= byte_s1;
			else if (cnt_q == 2'd1) held_q[1] <= byte_s1;
			else held_q[2] <= byte_s1;
		end
	end

endmodule

`default_nettype wire

### src/u8sd_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module u8sd_outq
	import u8sd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         load,
	input  wire dec_t   dec,
	output logic        can_load,
	u8sd_out_if.source  chars
);

	res_t       ent_q [MAX_RES];
	logic [1:0] cnt_q;
	logic       pop;

	assign pop = (cnt_q != 2'd0) && chars.ready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && chars.ready);

	// head entry drives the channel
	assign chars.valid = cnt_q != 2'd0;
	assign chars.code_point = ent_q[0].code_point;
	assign chars.used_bytes = ent_q[0].used_bytes;
	assign chars.stream_end = ent_q[0].stream_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= dec.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// load a fresh set or shift toward the head
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q[0] <= dec.res[0];
			ent_q[1] <= dec.res[1];
			ent_q[2] <= dec.res[2];
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

endmodule

`default_nettype wire

### src/utf8_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | role | payload
// bytes   | sink   | in_byte[7:0], is_last
// chars   | source | code_point[20:0], used_bytes[2:0], stream_end
//
// a byte moves from the input register into the result queue once the queue can take it;
// one beat per cycle on both sides while each byte gives at most one result and chars is ready.
// a cut-off tail at stream end gives up to three results, drained from the
// three-entry result queue one per cycle while chars is ready.
// reset clears the held sequence and empties both registers.
// a stalled chars side holds the queue and then the input register.

module utf8_stream_decoder
	import u8sd_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	u8sd_in_if.sink    bytes,
	u8sd_out_if.source chars
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;
	logic       can_load;
	dec_t       dec;

	// a byte with no result never waits for the queue
	assign adv = valid_s1 && (dec.count == 2'd0 || can_load);
	assign bytes.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
			last_s1 <= bytes.is_last;
		end
	end

	u8sd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.take    (adv),
		.dec     (dec)
	);

	u8sd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && dec.count != 2'd0),
		.dec      (dec),
		.can_load (can_load),
		.chars    (chars)
	);

endmodule

`default_nettype wire

### tb/sv/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
	import u8sd_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	u8sd_in_if  byte_ch ();
	u8sd_out_if char_ch ();

	utf8_stream_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.chars  (char_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// decoder mirror: bytes of the open sequence, their count, announced length
	logic [2:0][7:0] held = '0;
	logic [1:0]      held_cnt = '0;
	logic [2:0]      need_len = '0;
	res_t            pending_chars [$];

	// idling knobs and counters
	int src_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int fails = 0;
	int bytes_sent = 0;
	int chars_checked = 0;
	int ends_seen = 0;
	int conts_left = 0;

	// length announced by a lead byte
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		if (b[7] == 1'b0)
			return LEN_ONE;
		if (b[7:5] == 3'b110)
			return LEN_TWO;
		if (b[7:4] == 4'b1110)
			return LEN_THREE;
		if (b[7:3] == 5'b11110)
			return LEN_FOUR;
		return LEN_BAD;
	endfunction

	// decode the first n bytes of seq as a closed run, queue every char
	function automatic void decode_run(input logic [3:0][7:0] seq, input int n,
		input logic last);
		int          pos;
		logic [2:0]  len;
		logic [20:0] cp;
		res_t        r;
		pos = 0;
		while (pos < n) begin
			len = lead_len(seq[pos]);
			if (len == LEN_ONE) begin
				r.code_point = {13'd0, seq[pos]};
				r.used_bytes = LEN_ONE;
			end else if (len != LEN_BAD && pos + len <= n) begin
				case (len)
					LEN_TWO:   cp = {16'd0, seq[pos][4:0]};
					LEN_THREE: cp = {17'd0, seq[pos][3:0]};
					default:   cp = {18'd0, seq[pos][2:0]};
				endcase
				for (int j = 1; j < len; j++)
					cp = (cp << 6) | {15'd0, seq[pos + j][5:0]};
				r.code_point = cp;
				r.used_bytes = len;
			end else begin
				r.code_point = QMARK;
				r.used_bytes = LEN_ONE;
			end
			pos += r.used_bytes;
			r.stream_end = last && (pos >= n);
			pending_chars = {pending_chars, r};
		end
	endfunction

	// advance the mirror by one accepted byte
	function automatic void decode_byte(input logic [7:0] b, input logic last);
		logic [3:0][7:0] seq;
		logic [2:0]      len;
		res_t            r;
		int              n;
		seq = {8'd0, held};
		seq[held_cnt] = b;
		n = held_cnt + 1;
		len = lead_len(b);
		if (last) begin
			decode_run(seq, n, 1'b1);
			held_cnt = '0;
			need_len = '0;
		end else if (held_cnt == 0) begin
			if (len == LEN_ONE || len == LEN_BAD) begin
				r.code_point = (len == LEN_ONE) ? {13'd0, b} : QMARK;
				r.used_bytes = LEN_ONE;
				r.stream_end = 1'b0;
				pending_chars = {pending_chars, r};
			end else begin
				need_len = len;
				held[0] = b;
				held_cnt = 2'd1;
			end
		end else if (n >= need_len) begin
			decode_run(seq, n, 1'b0);
			held_cnt = '0;
			need_len = '0;
		end else begin
			held[held_cnt] = b;
			held_cnt++;
		end
	endfunction

	// check chars against the oldest pending one, then mirror accepted bytes
	always @(posedge clk) begin : watch
		res_t want;
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (pending_chars.size() == 0) begin
				$error("char with nothing pending: code_point %0d used_bytes %0d stream_end %0d",
					char_ch.code_point, char_ch.used_bytes, char_ch.stream_end);
				fails++;
			end else begin
				want = pending_chars.pop_front();
				if (char_ch.code_point !== want.code_point) begin
					$error("code_point: expected %0d, got %0d", want.code_point,
						char_ch.code_point);
					fails++;
				end
				if (char_ch.used_bytes !== want.used_bytes) begin
					$error("used_bytes: expected %0d, got %0d", want.used_bytes,
						char_ch.used_bytes);
					fails++;
				end
				if (char_ch.stream_end !== want.stream_end) begin
					$error("stream_end: expected %0d, got %0d", want.stream_end,
						char_ch.stream_end);
					fails++;
				end
				chars_checked++;
				if (want.stream_end)
					ends_seen++;
			end
		end
		if (arst_n && byte_ch.valid && byte_ch.ready)
			decode_byte(byte_ch.in_byte, byte_ch.is_last);
	end

	// chars side ready: long hold-off when asked, random stalls otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			char_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			char_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// one byte beat, called and returning at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		byte_ch.is_last <= last;
		do @(posedge clk); while (!byte_ch.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// stop offering and wait for every pending char
	task automatic drain();
		byte_ch.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_idling(input int src_pct, input int snk_pct);
		@(posedge clk);
		src_idle_pct = src_pct;
		stall_pct = snk_pct;
		@(negedge clk);
	endtask

	// plain ascii extremes and leads that are never valid
	task automatic test_single_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hF8, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b1);
		drain();
	endtask

	// complete two-, three- and four-byte sequences, sloppy continuations
	task automatic test_sequences();
		send_byte(8'hC2, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		// continuation top bits are ignored
		send_byte(8'hC3, 1'b0);
		send_byte(8'hFF, 1'b0);
		// largest code point, completed on the stream's last byte
		send_byte(8'hF7, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b1);
		drain();
	endtask

	// stream ends on a lead and in the middle of sequences
	task automatic test_stream_ends();
		send_byte(8'hE2, 1'b1);
		// cut-off lead, then a two-byte tail that still fits
		send_byte(8'hF0, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b1);
		// three chars from one final byte
		send_byte(8'hF0, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h41, 1'b1);
		// held continuation decoded again as a bad lead
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
		drain();
	endtask

	// chars side held off while bytes keep coming, so the input backs up
	task automatic test_backpressure();
		set_idling(0, 0);
		@(posedge clk);
		hold_left = 120;
		@(negedge clk);
		for (int i = 0; i < 12; i++)
			send_byte(8'(8'h41 + i), 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h5A, 1'b1);
		send_byte(8'hF0, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h30, 1'b1);
		drain();
	endtask

	// mostly well-formed streams with random content, some noise and cut tails
	task automatic test_random_streams(input int count, input int src_pct, input int snk_pct);
		logic [7:0] r;
		logic [7:0] b;
		logic       last;
		set_idling(src_pct, snk_pct);
		for (int i = 0; i < count; i++) begin
			r = 8'($urandom);
			if (conts_left > 0) begin
				b = ($urandom_range(9) == 0) ? r : {2'b10, r[5:0]};
				conts_left--;
			end else begin
				case ($urandom_range(9))
					0, 1, 2: b = {1'b0, r[6:0]};
					3, 4: begin
						b = {3'b110, r[4:0]};
						conts_left = 1;
					end
					5: begin
						b = {4'b1110, r[3:0]};
						conts_left = 2;
					end
					6, 7: begin
						b = {5'b11110, r[2:0]};
						conts_left = 3;
					end
					8: b = r[7] ? {5'b11111, r[2:0]} : {2'b10, r[5:0]};
					default: b = r;
				endcase
			end
			last = ($urandom_range(11) == 0);
			if (last)
				conts_left = 0;
			send_byte(b, last);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = '0;
		byte_ch.is_last = 1'b0;
		char_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_single_bytes();
		test_sequences();
		test_stream_ends();
		test_backpressure();
		test_random_streams(42, 0, 0);
		test_random_streams(42, 75, 0);
		test_random_streams(42, 0, 75);
		test_random_streams(42, 24, 24);

		repeat (20) @(posedge clk);
		$display("%0d bytes in, %0d chars checked, %0d stream ends", bytes_sent,
			chars_checked, ends_seen);
		$display("phases: free flow, sparse bytes, slow chars, both, long hold-off");
		if (fails == 0)
			$display("tb_utf8_stream_decoder passed");
		else
			$display("tb_utf8_stream_decoder failed");
		$finish;
	end

	// hang guard
	initial begin
		#2000000;
		$display("tb_utf8_stream_decoder failed");
		$finish;
	end

endmodule

### sim.f
src/u8sd_pkg.sv
src/u8sd_in_if.sv
src/u8sd_out_if.sv
src/u8sd_core.sv
src/u8sd_outq.sv
src/utf8_stream_decoder.sv
tb/sv/tb_utf8_stream_decoder.sv
